[sv/pvk_pkg.sv]
// pvk_pkg: shared types, codes and constants of the 2d position/velocity kalman filter
// no dependencies; used by the interfaces' users, the arithmetic unit and the top level
package pvk_pkg;

	localparam int DT_BITS   = 16;
	localparam int GAIN_FRAC = 30;
	localparam int DVD_W     = 64 + GAIN_FRAC;

	localparam logic [1:0] REQ_PREDICT = 2'd0;
	localparam logic [1:0] REQ_CORRECT = 2'd1;
	localparam logic [1:0] REQ_RESTORE = 2'd2;

	localparam logic [2:0] REG_PROC_NOISE  = 3'd0;
	localparam logic [2:0] REG_MEAS_NOISE  = 3'd1;
	localparam logic [2:0] REG_MIN_QUAL    = 3'd2;
	localparam logic [2:0] REG_ACC_DBAND   = 3'd3;
	localparam logic [2:0] REG_STILL_LIMIT = 3'd4;

	localparam logic [7:0] QUAL_SCALE = 8'd200;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIVG,
		ALU_DIVP
	} alu_op_t;

	typedef enum logic [1:0] {
		SAT_FLD,
		SAT_64,
		SAT_COV
	} sat_w_t;

	typedef struct packed {
		alu_op_t            op;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [5:0]         sh;
		sat_w_t             w;
	} alu_cmd_t;

	function automatic logic [63:0] mag64(logic signed [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic [31:0] mag32(logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// sign and magnitude back to two's complement, saturated at +lim and at -lim-1
	function automatic logic signed [63:0] sfrom(logic neg, logic [63:0] m, logic [63:0] lim);
		logic [63:0] v;
		if (m > lim) begin
			v = neg ? ~lim : lim;
		end else begin
			v = neg ? (~m + 64'd1) : m;
		end
		return $signed(v);
	endfunction

endpackage

[sv/pvk_if.sv]
// pvk_in_if / pvk_out_if: valid/ready channels carrying one request and one state report
// no dependencies
interface pvk_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] accel_x;
	logic signed [31:0] accel_y;
	logic [15:0]        time_step;
	logic signed [31:0] flow_x;
	logic signed [31:0] flow_y;
	logic [7:0]         flow_quality;

	modport source (
		output valid, req_type, accel_x, accel_y, time_step, flow_x, flow_y, flow_quality,
		input  ready
	);
	modport sink (
		input  valid, req_type, accel_x, accel_y, time_step, flow_x, flow_y, flow_quality,
		output ready
	);
endinterface

interface pvk_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;

	modport source (
		output valid, position_x, position_y, velocity_x, velocity_y,
		input  ready
	);
	modport sink (
		input  valid, position_x, position_y, velocity_x, velocity_y,
		output ready
	);
endinterface

[sv/position_velocity_kalman_2d.sv]
// position_velocity_kalman_2d: two-axis constant-velocity kalman filter, one item at a time
// restore/unknown request: straight to result; predict: dt and noise terms, then per axis the
// multiply/add steps (no position update when frozen); correct: measurement noise (quality
// division only for nonzero quality at or above the minimum), then per axis gain and
// update steps, all run on the shared pvk_alu; input ready only while idle, result
// held in an output register; asynchronous active-low reset restores state and register defaults
module position_velocity_kalman_2d #(
	parameter int FRAC_BITS = 16,
	parameter int COV_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	pvk_in_if.sink      in_ch,
	pvk_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pvk_pkg::*;

	localparam logic [30:0] PN_RST  = 31'(100 * (1 << FRAC_BITS));
	localparam logic [30:0] MN_RST  = 31'(25 * (1 << FRAC_BITS));
	localparam logic [7:0]  MQ_RST  = 8'd50;
	localparam logic [30:0] DB_RST  = 31'(4 * (1 << FRAC_BITS));
	localparam logic [30:0] SL_RST  = 31'(2 * (1 << FRAC_BITS));
	localparam logic signed [COV_WIDTH-1:0] PP_RST = COV_WIDTH'(100 * (1 << FRAC_BITS));
	localparam logic signed [COV_WIDTH-1:0] PV_RST = COV_WIDTH'(50 * (1 << FRAC_BITS));
	localparam logic [63:0] COV_MAX = (64'd1 << (COV_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] BIG_RAW = 64'd1000000 << FRAC_BITS;
	localparam logic signed [COV_WIDTH-1:0] R_BIG =
		COV_WIDTH'((BIG_RAW > COV_MAX) ? COV_MAX : BIG_RAW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [5:0] {
		S_DT2, S_QV, S_QP, S_PV1, S_PA1, S_PSUM, S_PPOS, S_VA, S_VVEL,
		S_CPC, S_CPV, S_CSUM, S_PP, S_CTMP, S_PC, S_PPQ, S_PVQ,
		C_RMUL, C_RADD, C_RDIV, C_S, C_KP, C_KV, C_E, C_MP, C_POS, C_MV, C_VEL,
		C_M1, C_PP, C_M2, C_PC, C_M3, C_PV
	} step_t;

	logic [30:0] pn_q;
	logic [30:0] mn_q;
	logic [7:0]  mq_q;
	logic [30:0] db_q;
	logic [30:0] sl_q;

	state_t st_q;
	step_t  step_q;
	logic   axis_q;
	logic   wait_q;

	logic signed [31:0]          pos_q [2];
	logic signed [31:0]          vel_q [2];
	logic signed [COV_WIDTH-1:0] pp_q  [2];
	logic signed [COV_WIDTH-1:0] pv_q  [2];
	logic signed [COV_WIDTH-1:0] pc_q  [2];

	logic [15:0]                 dt_q;
	logic signed [31:0]          acc_q [2];
	logic signed [31:0]          flow_q [2];
	logic [7:0]                  qual_q;
	logic                        frozen_q;
	logic [31:0]                 dt2_q;
	logic signed [COV_WIDTH-1:0] qv_q;
	logic signed [COV_WIDTH-1:0] qp_q;
	logic signed [COV_WIDTH-1:0] r_q;
	logic signed [COV_WIDTH-1:0] s_q;
	logic signed [63:0]          kp_q;
	logic signed [63:0]          kv_q;
	logic signed [32:0]          e_q;
	logic signed [63:0]          t0_q;
	logic signed [63:0]          t1_q;

	logic               ov_q;
	logic signed [31:0] opx_q;
	logic signed [31:0] opy_q;
	logic signed [31:0] ovx_q;
	logic signed [31:0] ovy_q;

	logic               alu_start;
	alu_cmd_t           alu_cmd;
	logic               alu_done;
	logic signed [63:0] alu_res;

	logic signed [63:0] pos_c;
	logic signed [63:0] vel_c;
	logic signed [63:0] pp_c;
	logic signed [63:0] pv_c;
	logic signed [63:0] pc_c;
	logic signed [63:0] acc_c;
	logic signed [31:0] ax_eff;
	logic signed [31:0] ay_eff;
	logic               still;
	logic               cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= PN_RST;
			mn_q <= MN_RST;
			mq_q <= MQ_RST;
			db_q <= DB_RST;
			sl_q <= SL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_PROC_NOISE:  pn_q <= pwdata[30:0];
				REG_MEAS_NOISE:  mn_q <= pwdata[30:0];
				REG_MIN_QUAL:    mq_q <= pwdata[7:0];
				REG_ACC_DBAND:   db_q <= pwdata[30:0];
				REG_STILL_LIMIT: sl_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_PROC_NOISE:  prdata = {1'b0, pn_q};
			REG_MEAS_NOISE:  prdata = {1'b0, mn_q};
			REG_MIN_QUAL:    prdata = {24'd0, mq_q};
			REG_ACC_DBAND:   prdata = {1'b0, db_q};
			REG_STILL_LIMIT: prdata = {1'b0, sl_q};
			default:         prdata = '0;
		endcase
	end

	// request decode at acceptance
	always_comb begin
		ax_eff = (mag32(in_ch.accel_x) < {1'b0, db_q}) ? '0 : in_ch.accel_x;
		ay_eff = (mag32(in_ch.accel_y) < {1'b0, db_q}) ? '0 : in_ch.accel_y;
		still  = (mag32(vel_q[0]) < {1'b0, sl_q}) && (mag32(vel_q[1]) < {1'b0, sl_q});
	end

	assign pos_c = 64'(pos_q[axis_q]);
	assign vel_c = 64'(vel_q[axis_q]);
	assign pp_c  = 64'(pp_q[axis_q]);
	assign pv_c  = 64'(pv_q[axis_q]);
	assign pc_c  = 64'(pc_q[axis_q]);
	assign acc_c = 64'(acc_q[axis_q]);

	assign alu_start = (st_q == ST_RUN) && !wait_q;

	// operation issued to the shared unit for each step
	always_comb begin
		alu_cmd = '{op: ALU_ADD, a: '0, b: '0, sh: '0, w: SAT_64};
		unique case (step_q)
			S_DT2:  alu_cmd = '{ALU_MUL, 64'(dt_q), 64'(dt_q), 6'd0, SAT_64};
			S_QV:   alu_cmd = '{ALU_MUL, 64'(pn_q), 64'(dt2_q), 6'(2 * DT_BITS), SAT_COV};
			S_QP:   alu_cmd = '{ALU_MUL, 64'(qv_q), 64'(dt2_q), 6'(2 * DT_BITS + 2), SAT_COV};
			S_PV1:  alu_cmd = '{ALU_MUL, vel_c, 64'(dt_q), 6'(DT_BITS), SAT_64};
			S_PA1:  alu_cmd = '{ALU_MUL, acc_c, 64'(dt2_q), 6'(2 * DT_BITS + 1), SAT_64};
			S_PSUM: alu_cmd = '{ALU_ADD, t0_q, t1_q, 6'd0, SAT_64};
			S_PPOS: alu_cmd = '{ALU_ADD, pos_c, t0_q, 6'd0, SAT_FLD};
			S_VA:   alu_cmd = '{ALU_MUL, acc_c, 64'(dt_q), 6'(DT_BITS), SAT_64};
			S_VVEL: alu_cmd = '{ALU_ADD, vel_c, t1_q, 6'd0, SAT_FLD};
			S_CPC:  alu_cmd = '{ALU_MUL, pc_c, 64'(dt_q), 6'(DT_BITS - 1), SAT_64};
			S_CPV:  alu_cmd = '{ALU_MUL, pv_c, 64'(dt2_q), 6'(2 * DT_BITS), SAT_64};
			S_CSUM: alu_cmd = '{ALU_ADD, t0_q, t1_q, 6'd0, SAT_64};
			S_PP:   alu_cmd = '{ALU_ADD, pp_c, t0_q, 6'd0, SAT_COV};
			S_CTMP: alu_cmd = '{ALU_MUL, pv_c, 64'(dt_q), 6'(DT_BITS), SAT_64};
			S_PC:   alu_cmd = '{ALU_ADD, pc_c, t1_q, 6'd0, SAT_COV};
			S_PPQ:  alu_cmd = '{ALU_ADD, pp_c, 64'(qp_q), 6'd0, SAT_COV};
			S_PVQ:  alu_cmd = '{ALU_ADD, pv_c, 64'(qv_q), 6'd0, SAT_COV};
			C_RMUL: alu_cmd = '{ALU_MUL, 64'(mn_q), 64'(QUAL_SCALE), 6'd0, SAT_64};
			C_RADD: alu_cmd = '{ALU_ADD, t0_q, 64'(qual_q[7:1]), 6'd0, SAT_64};
			C_RDIV: alu_cmd = '{ALU_DIVP, t0_q, 64'(qual_q), 6'd0, SAT_COV};
			C_S:    alu_cmd = '{ALU_ADD, pv_c, 64'(r_q), 6'd0, SAT_COV};
			C_KP:   alu_cmd = '{ALU_DIVG, pc_c, 64'(s_q), 6'd0, SAT_64};
			C_KV:   alu_cmd = '{ALU_DIVG, pv_c, 64'(s_q), 6'd0, SAT_64};
			C_E:    alu_cmd = '{ALU_SUB, 64'(flow_q[axis_q]), vel_c, 6'd0, SAT_64};
			C_MP:   alu_cmd = '{ALU_MUL, kp_q, 64'(e_q), 6'(GAIN_FRAC), SAT_64};
			C_POS:  alu_cmd = '{ALU_ADD, pos_c, t0_q, 6'd0, SAT_FLD};
			C_MV:   alu_cmd = '{ALU_MUL, kv_q, 64'(e_q), 6'(GAIN_FRAC), SAT_64};
			C_VEL:  alu_cmd = '{ALU_ADD, vel_c, t0_q, 6'd0, SAT_FLD};
			C_M1:   alu_cmd = '{ALU_MUL, kp_q, pc_c, 6'(GAIN_FRAC), SAT_64};
			C_PP:   alu_cmd = '{ALU_SUB, pp_c, t0_q, 6'd0, SAT_COV};
			C_M2:   alu_cmd = '{ALU_MUL, kp_q, pv_c, 6'(GAIN_FRAC), SAT_64};
			C_PC:   alu_cmd = '{ALU_SUB, pc_c, t0_q, 6'd0, SAT_COV};
			C_M3:   alu_cmd = '{ALU_MUL, kv_q, pv_c, 6'(GAIN_FRAC), SAT_64};
			C_PV:   alu_cmd = '{ALU_SUB, pv_c, t0_q, 6'd0, SAT_COV};
			default: ;
		endcase
	end

	pvk_alu #(
		.COV_WIDTH (COV_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.cmd    (alu_cmd),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= S_DT2;
			axis_q <= 1'b0;
			wait_q <= 1'b0;
			ov_q   <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				pp_q[i]  <= PP_RST;
				pv_q[i]  <= PV_RST;
				pc_q[i]  <= '0;
			end
		end else begin
			if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						dt_q      <= in_ch.time_step;
						acc_q[0]  <= ax_eff;
						acc_q[1]  <= ay_eff;
						flow_q[0] <= in_ch.flow_x;
						flow_q[1] <= in_ch.flow_y;
						qual_q    <= in_ch.flow_quality;
						frozen_q  <= still && (ax_eff == '0) && (ay_eff == '0);
						axis_q    <= 1'b0;
						wait_q    <= 1'b0;
						unique case (in_ch.req_type)
							REQ_PREDICT: begin
								step_q <= S_DT2;
								st_q   <= ST_RUN;
							end
							REQ_CORRECT: begin
								step_q <= C_RMUL;
								st_q   <= ST_RUN;
							end
							REQ_RESTORE: begin
								for (int i = 0; i < 2; i++) begin
									pos_q[i] <= '0;
									vel_q[i] <= '0;
									pp_q[i]  <= PP_RST;
									pv_q[i]  <= PV_RST;
									pc_q[i]  <= '0;
								end
								st_q <= ST_FIN;
							end
							default: st_q <= ST_FIN;
						endcase
					end
				end
				ST_RUN: begin
					if (alu_start) begin
						wait_q <= 1'b1;
					end
					if (alu_done) begin
						wait_q <= 1'b0;
						unique case (step_q)
							S_DT2: begin
								dt2_q  <= alu_res[31:0];
								step_q <= S_QV;
							end
							S_QV: begin
								qv_q   <= alu_res[COV_WIDTH-1:0];
								step_q <= S_QP;
							end
							S_QP: begin
								qp_q   <= alu_res[COV_WIDTH-1:0];
								step_q <= S_PV1;
							end
							S_PV1: begin
								t0_q   <= alu_res;
								step_q <= S_PA1;
							end
							S_PA1: begin
								t1_q   <= alu_res;
								step_q <= S_PSUM;
							end
							S_PSUM: begin
								t0_q   <= alu_res;
								step_q <= frozen_q ? S_VA : S_PPOS;
							end
							S_PPOS: begin
								pos_q[axis_q] <= alu_res[31:0];
								step_q        <= S_VA;
							end
							S_VA: begin
								t1_q   <= alu_res;
								step_q <= S_VVEL;
							end
							S_VVEL: begin
								vel_q[axis_q] <= alu_res[31:0];
								step_q        <= S_CPC;
							end
							S_CPC: begin
								t0_q   <= alu_res;
								step_q <= S_CPV;
							end
							S_CPV: begin
								t1_q   <= alu_res;
								step_q <= S_CSUM;
							end
							S_CSUM: begin
								t0_q   <= alu_res;
								step_q <= S_PP;
							end
							S_PP: begin
								pp_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								step_q       <= S_CTMP;
							end
							S_CTMP: begin
								t1_q   <= alu_res;
								step_q <= S_PC;
							end
							S_PC: begin
								pc_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								step_q       <= S_PPQ;
							end
							S_PPQ: begin
								pp_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								step_q       <= S_PVQ;
							end
							S_PVQ: begin
								pv_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								if (!axis_q) begin
									axis_q <= 1'b1;
									step_q <= S_PV1;
								end else begin
									st_q <= ST_FIN;
								end
							end
							C_RMUL: begin
								t0_q   <= alu_res;
								step_q <= C_RADD;
							end
							C_RADD: begin
								t0_q <= alu_res;
								if ((qual_q != 8'd0) && (qual_q >= mq_q)) begin
									step_q <= C_RDIV;
								end else begin
									r_q    <= (qual_q < mq_q) ? R_BIG :
										$signed({{(COV_WIDTH - 31){1'b0}}, mn_q});
									step_q <= C_S;
								end
							end
							C_RDIV: begin
								r_q    <= alu_res[COV_WIDTH-1:0];
								step_q <= C_S;
							end
							C_S: begin
								s_q    <= (alu_res < 64'sd1) ? COV_WIDTH'(1) :
									alu_res[COV_WIDTH-1:0];
								step_q <= C_KP;
							end
							C_KP: begin
								kp_q   <= alu_res;
								step_q <= C_KV;
							end
							C_KV: begin
								kv_q   <= alu_res;
								step_q <= C_E;
							end
							C_E: begin
								e_q    <= alu_res[32:0];
								step_q <= C_MP;
							end
							C_MP: begin
								t0_q   <= alu_res;
								step_q <= C_POS;
							end
							C_POS: begin
								pos_q[axis_q] <= alu_res[31:0];
								step_q        <= C_MV;
							end
							C_MV: begin
								t0_q   <= alu_res;
								step_q <= C_VEL;
							end
							C_VEL: begin
								vel_q[axis_q] <= alu_res[31:0];
								step_q        <= C_M1;
							end
							C_M1: begin
								t0_q   <= alu_res;
								step_q <= C_PP;
							end
							C_PP: begin
								pp_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								step_q       <= C_M2;
							end
							C_M2: begin
								t0_q   <= alu_res;
								step_q <= C_PC;
							end
							C_PC: begin
								pc_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								step_q       <= C_M3;
							end
							C_M3: begin
								t0_q   <= alu_res;
								step_q <= C_PV;
							end
							C_PV: begin
								pv_q[axis_q] <= alu_res[COV_WIDTH-1:0];
								if (!axis_q) begin
									axis_q <= 1'b1;
									step_q <= C_S;
								end else begin
									st_q <= ST_FIN;
								end
							end
							default: st_q <= ST_FIN;
						endcase
					end
				end
				ST_FIN: begin
					if (!ov_q || out_ch.ready) begin
						ov_q  <= 1'b1;
						opx_q <= pos_q[0];
						opy_q <= pos_q[1];
						ovx_q <= vel_q[0];
						ovy_q <= vel_q[1];
						st_q  <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready       = (st_q == ST_IDLE);
	assign out_ch.valid      = ov_q;
	assign out_ch.position_x = opx_q;
	assign out_ch.position_y = opy_q;
	assign out_ch.velocity_x = ovx_q;
	assign out_ch.velocity_y = ovy_q;

endmodule

[sv/pvk_alu.sv]
// pvk_alu: shared saturating add/sub, 64x64 multiply-round-shift and restoring divider
// depends on pvk_pkg; one 32x32 multiplier reused for four partial products, divider one bit a cycle
module pvk_alu #(
	parameter int COV_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pvk_pkg::alu_cmd_t  cmd,
	output logic               done,
	output logic signed [63:0] res
);
	import pvk_pkg::*;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_RND,
		A_SHF,
		A_DIV,
		A_DRND
	} astate_t;

	astate_t            st_q;
	alu_op_t            op_q;
	sat_w_t             w_q;
	logic [5:0]         sh_q;
	logic               neg_q;
	logic [63:0]        ua_q;
	logic [63:0]        ub_q;
	logic [6:0]         cnt_q;
	logic [63:0]        pp_q;
	logic [127:0]       acc_q;
	logic [63:0]        r_q;
	logic [63:0]        q_q;
	logic               ovf_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [63:0]        d_q;
	logic signed [63:0] res_q;
	logic               done_q;

	logic [63:0]        lim_cmd;
	logic [63:0]        lim;
	logic signed [64:0] sum65;
	logic signed [64:0] hi65;
	logic signed [63:0] add_res;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [1:0]         pcnt;
	logic [127:0]       pp_sh;
	logic [127:0]       rnd_add;
	logic [127:0]       shifted;
	logic [64:0]        r2;
	logic               ge;
	logic               rnd_up;
	logic [63:0]        q_fin;

	function automatic logic [63:0] lim_of(sat_w_t w);
		logic [63:0] v;
		unique case (w)
			SAT_FLD: v = 64'h0000_0000_7FFF_FFFF;
			SAT_64:  v = 64'h7FFF_FFFF_FFFF_FFFF;
			default: v = (64'd1 << (COV_WIDTH - 1)) - 64'd1;
		endcase
		return v;
	endfunction

	always_comb begin
		lim_cmd = lim_of(cmd.w);
		lim     = lim_of(w_q);
		if (cmd.op == ALU_SUB) begin
			sum65 = 65'(cmd.a) - 65'(cmd.b);
		end else begin
			sum65 = 65'(cmd.a) + 65'(cmd.b);
		end
		hi65 = $signed({1'b0, lim_cmd});
		if (sum65 > hi65) begin
			add_res = $signed(lim_cmd);
		end else if (sum65 < ~hi65) begin
			add_res = $signed(~lim_cmd);
		end else begin
			add_res = sum65[63:0];
		end

		mul_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		mul_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		pcnt  = cnt_q[1:0] - 2'd1;
		case (pcnt)
			2'b00:   pp_sh = {64'd0, pp_q};
			2'b11:   pp_sh = {pp_q, 64'd0};
			default: pp_sh = {32'd0, pp_q, 32'd0};
		endcase
		rnd_add = (sh_q == 6'd0) ? 128'd0 : (128'd1 << (sh_q - 6'd1));
		shifted = acc_q >> sh_q;

		r2     = {r_q, dvd_q[DVD_W-1]};
		ge     = r2 >= {1'b0, d_q};
		rnd_up = (op_q == ALU_DIVG) && ({r_q, 1'b0} >= {1'b0, d_q});
		q_fin  = (ovf_q || (rnd_up && (&q_q))) ? '1 : (q_q + 64'(rnd_up));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			op_q   <= ALU_ADD;
			w_q    <= SAT_64;
			sh_q   <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (start) begin
						op_q  <= cmd.op;
						w_q   <= cmd.w;
						sh_q  <= cmd.sh;
						cnt_q <= '0;
						unique case (cmd.op) inside
							ALU_ADD, ALU_SUB: begin
								res_q  <= add_res;
								done_q <= 1'b1;
							end
							ALU_MUL: begin
								ua_q  <= mag64(cmd.a);
								ub_q  <= mag64(cmd.b);
								neg_q <= cmd.a[63] ^ cmd.b[63];
								acc_q <= '0;
								st_q  <= A_MUL;
							end
							default: begin
								if (cmd.op == ALU_DIVG) begin
									dvd_q <= {mag64(cmd.a), {GAIN_FRAC{1'b0}}};
								end else begin
									dvd_q <= {{GAIN_FRAC{1'b0}}, cmd.a};
								end
								neg_q <= (cmd.op == ALU_DIVG) && cmd.a[63];
								d_q   <= cmd.b;
								r_q   <= '0;
								q_q   <= '0;
								ovf_q <= 1'b0;
								st_q  <= A_DIV;
							end
						endcase
					end
				end
				A_MUL: begin
					if (cnt_q != 7'd0) begin
						acc_q <= acc_q + pp_sh;
					end
					pp_q  <= mul_a * mul_b;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd4) begin
						st_q <= A_RND;
					end
				end
				A_RND: begin
					acc_q <= acc_q + rnd_add;
					st_q  <= A_SHF;
				end
				A_SHF: begin
					if (|shifted[127:64]) begin
						res_q <= sfrom(neg_q, '1, lim);
					end else begin
						res_q <= sfrom(neg_q, shifted[63:0], lim);
					end
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				A_DIV: begin
					dvd_q <= dvd_q << 1;
					ovf_q <= ovf_q | q_q[63];
					q_q   <= {q_q[62:0], ge};
					r_q   <= ge ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(DVD_W - 1)) begin
						st_q <= A_DRND;
					end
				end
				A_DRND: begin
					res_q  <= sfrom(neg_q, q_fin, lim);
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[sv/pvk_chk.sv]
// pvk_chk: port-level checks of the kalman filter's request and result channels
// no dependencies; bound to position_velocity_kalman_2d at the end of this file
module pvk_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// held result stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// a fresh result only appears at the end of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without request");

	// no result during reset
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid in reset");

endmodule

bind position_velocity_kalman_2d pvk_chk u_pvk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);

[tb/tb_position_velocity_kalman_2d.sv]
// tb_position_velocity_kalman_2d: self-checking testbench of the 2d position/velocity kalman filter
// drives requests and apb register writes, predicts each state report in fixed point or takes
// a typed one from the table, and compares; depends on pvk_pkg, pvk_in_if / pvk_out_if and position_velocity_kalman_2d
`timescale 1ns / 1ps

module tb_position_velocity_kalman_2d;
	import pvk_pkg::*;

	localparam int FRAC = 16;
	localparam int CW   = 48;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [31:0] F_MAX = 32'h7fffffff;
	localparam logic [31:0] F_MIN = 32'h80000000;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} kf_state_t;

	typedef struct {
		logic [1:0]         req;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic [15:0]        dt;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic [7:0]         q;
		bit                 typed;
		kf_state_t          est;
	} req_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	pvk_in_if  in_ch();
	pvk_out_if out_ch();

	position_velocity_kalman_2d DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// filter model state and register copies
	longint pos[2], vel[2], pvar_p[2], pvar_v[2], pvar_c[2];
	longint proc_noise, meas_noise, min_qual, acc_dband, still_lim;

	kf_state_t state_q[$];
	req_row_t  typed_q[$];
	int mismatches = 0;
	int accepted = 0;
	bit quiet = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("position_velocity_kalman_2d test failed");
		$finish;
	end

	function automatic longint lim_of(int w);
		if (w >= 64) return 64'sh7fffffffffffffff;
		return (64'sd1 <<< (w - 1)) - 1;
	endfunction

	function automatic logic [63:0] umag(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint from_mag(bit neg, logic [63:0] m, int w);
		logic [63:0] l;
		l = 64'(lim_of(w));
		if (m > l) return neg ? -lim_of(w) - 1 : lim_of(w);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sat(logic signed [65:0] s, int w);
		logic signed [65:0] l;
		l = lim_of(w);
		if (s > l) return lim_of(w);
		if (s < -l - 1) return -lim_of(w) - 1;
		return longint'(s);
	endfunction

	function automatic longint add_sat(longint a, longint b, int w);
		logic signed [65:0] s;
		s = a;
		s = s + b;
		return sat(s, w);
	endfunction

	function automatic longint sub_sat(longint a, longint b, int w);
		logic signed [65:0] s;
		s = a;
		s = s - b;
		return sat(s, w);
	endfunction

	function automatic longint mul_round(longint a, longint b, int s, int w);
		logic [127:0] p, ua, ub;
		bit neg;
		ua = umag(a);
		ub = umag(b);
		neg = (a < 0) != (b < 0);
		p = ua * ub;
		if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
		if (p[127:64] != 0) return from_mag(neg, '1, w);
		return from_mag(neg, p[63:0], w);
	endfunction

	function automatic longint kalman_gain(longint n, longint d);
		logic [127:0] num, quo, rem, ud;
		logic [63:0] q;
		bit ovf;
		num = 128'(umag(n)) << GAIN_FRAC;
		ud = 128'(d);
		quo = num / ud;
		rem = num % ud;
		ovf = quo[127:64] != 0;
		q = quo[63:0];
		if (!ovf && rem >= ud - rem) begin
			if (q == '1) ovf = 1; else q = q + 1;
		end
		if (ovf) q = '1;
		return from_mag(n < 0, q, 64);
	endfunction

	function automatic void restore_filter();
		for (int i = 0; i < 2; i++) begin
			pos[i] = 0;
			vel[i] = 0;
			pvar_p[i] = 64'sd100 <<< FRAC;
			pvar_v[i] = 64'sd50 <<< FRAC;
			pvar_c[i] = 0;
		end
	endfunction

	function automatic void predict_filter(longint ax, longint ay, longint dt);
		longint acc[2], dt2, qv, qp, t, pv, pc;
		bit still;
		acc[0] = (umag(ax) < 64'(acc_dband)) ? 0 : ax;
		acc[1] = (umag(ay) < 64'(acc_dband)) ? 0 : ay;
		dt2 = dt * dt;
		still = umag(vel[0]) < 64'(still_lim) && umag(vel[1]) < 64'(still_lim);
		qv = mul_round(proc_noise, dt2, 2 * DT_BITS, CW);
		qp = mul_round(qv, dt2, 2 * DT_BITS + 2, CW);
		for (int i = 0; i < 2; i++) begin
			pv = pvar_v[i];
			pc = pvar_c[i];
			if (!(still && acc[0] == 0 && acc[1] == 0)) begin
				t = add_sat(mul_round(vel[i], dt, DT_BITS, 64),
					mul_round(acc[i], dt2, 2 * DT_BITS + 1, 64), 64);
				pos[i] = add_sat(pos[i], t, 32);
			end
			vel[i] = add_sat(vel[i], mul_round(acc[i], dt, DT_BITS, 64), 32);
			t = add_sat(mul_round(pc, dt, DT_BITS - 1, 64), mul_round(pv, dt2, 2 * DT_BITS, 64), 64);
			pvar_p[i] = add_sat(pvar_p[i], t, CW);
			pvar_c[i] = add_sat(pc, mul_round(pv, dt, DT_BITS, 64), CW);
			pvar_p[i] = add_sat(pvar_p[i], qp, CW);
			pvar_v[i] = add_sat(pv, qv, CW);
		end
	endfunction

	function automatic void correct_filter(longint fx, longint fy, longint q);
		longint r, s, kp, kv, e, pp, pv, pc, fl[2];
		fl[0] = fx;
		fl[1] = fy;
		r = meas_noise;
		if (q > 0) r = (meas_noise * 200 + q / 2) / q;
		if (q < min_qual) r = mul_round(1000000, 64'sd1 <<< FRAC, 0, CW);
		r = sat(r, CW);
		for (int i = 0; i < 2; i++) begin
			pp = pvar_p[i];
			pv = pvar_v[i];
			pc = pvar_c[i];
			s = add_sat(pv, r, CW);
			if (s < 1) s = 1;
			kp = kalman_gain(pc, s);
			kv = kalman_gain(pv, s);
			e = fl[i] - vel[i];
			pos[i] = add_sat(pos[i], mul_round(kp, e, GAIN_FRAC, 64), 32);
			vel[i] = add_sat(vel[i], mul_round(kv, e, GAIN_FRAC, 64), 32);
			pvar_p[i] = sub_sat(pp, mul_round(kp, pc, GAIN_FRAC, 64), CW);
			pvar_c[i] = sub_sat(pc, mul_round(kp, pv, GAIN_FRAC, 64), CW);
			pvar_v[i] = sub_sat(pv, mul_round(kv, pv, GAIN_FRAC, 64), CW);
		end
	endfunction

	function automatic kf_state_t step_filter(req_row_t t);
		kf_state_t s;
		case (t.req)
			REQ_PREDICT: predict_filter(t.ax, t.ay, t.dt);
			REQ_CORRECT: correct_filter(t.fx, t.fy, t.q);
			REQ_RESTORE: restore_filter();
			default: ;
		endcase
		s.px = pos[0][31:0];
		s.py = pos[1][31:0];
		s.vx = vel[0][31:0];
		s.vy = vel[1][31:0];
		return s;
	endfunction

	// request accepted: work out the state report it must produce
	always @(negedge clk) begin
		req_row_t t;
		kf_state_t s;
		if (in_ch.valid && in_ch.ready) begin
			t = typed_q.pop_front();
			s = step_filter(t);
			state_q.push_back(t.typed ? t.est : s);
			accepted++;
		end
	end

	always @(negedge clk) begin
		kf_state_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (state_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected state report at %0t", $realtime);
			end else begin
				e = state_q.pop_front();
				if (e !== {out_ch.position_x, out_ch.position_y, out_ch.velocity_x, out_ch.velocity_y})
					begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp px %0d py %0d vx %0d vy %0d got %0d %0d %0d %0d",
							e.px, e.py, e.vx, e.vy, out_ch.position_x, out_ch.position_y,
							out_ch.velocity_x, out_ch.velocity_y);
				end
			end
		end
	end

	// receiver: random bursts, one long hold-off after 40 accepted requests, none at the end
	initial begin
		bit held;
		bit calm;
		held = 0;
		calm = 0;
		out_ch.ready = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted >= 40) begin
				out_ch.ready <= 1'b0;
				repeat (1500) @(posedge clk);
				out_ch.ready <= 1'b1;
				held = 1;
			end else if (!quiet) begin
				if ($urandom_range(0, 99) == 0) calm = !calm;
				if (!calm && $urandom_range(0, 5) == 0) begin
					out_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 18)) @(posedge clk);
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PROC_NOISE:  proc_noise = val[30:0];
			REG_MEAS_NOISE:  meas_noise = val[30:0];
			REG_MIN_QUAL:    min_qual = val[7:0];
			REG_ACC_DBAND:   acc_dband = val[30:0];
			REG_STILL_LIMIT: still_lim = val[30:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (state_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_request(req_row_t t);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		typed_q.push_back(t);
		in_ch.valid <= 1'b1;
		in_ch.req_type <= t.req;
		in_ch.accel_x <= t.ax;
		in_ch.accel_y <= t.ay;
		in_ch.time_step <= t.dt;
		in_ch.flow_x <= t.fx;
		in_ch.flow_y <= t.fy;
		in_ch.flow_quality <= t.q;
		do @(negedge clk); while (!(in_ch.valid && in_ch.ready));
		@(posedge clk);
	endtask

	function automatic req_row_t row(logic [1:0] rq, logic [31:0] ax, logic [31:0] ay,
			logic [15:0] dt, logic [31:0] fx, logic [31:0] fy, logic [7:0] q, bit typed);
		req_row_t t;
		t.req = rq;
		t.ax = ax;
		t.ay = ay;
		t.dt = dt;
		t.fx = fx;
		t.fy = fy;
		t.q = q;
		t.typed = typed;
		t.est = '0;
		return t;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 9))
			0: return F_MAX;
			1: return F_MIN;
			2: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
			3, 4: return $urandom;
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 21))
				: -32'($urandom_range(0, 1 << 21));
		endcase
	endfunction

	function automatic req_row_t rand_request();
		logic [1:0] rq;
		logic [15:0] dt;
		int k;
		k = $urandom_range(0, 19);
		rq = k < 10 ? REQ_PREDICT : k < 18 ? REQ_CORRECT : k == 18 ? REQ_RESTORE : REQ_UNUSED;
		dt = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
		return row(rq, rand_field(), rand_field(), dt, rand_field(), rand_field(),
			8'($urandom_range(0, 255)), 0);
	endfunction

	initial begin
		req_row_t dir_tab[$];
		int n_sent;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_RESTORE;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.time_step = '0;
		in_ch.flow_x = '0;
		in_ch.flow_y = '0;
		in_ch.flow_quality = '0;
		proc_noise = 6553600;
		meas_noise = 1638400;
		min_qual = 50;
		acc_dband = 262144;
		still_lim = 131072;
		restore_filter();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// state still at rest: restore, zero time step, dead-banded input, unknown request
		dir_tab.push_back(row(REQ_RESTORE, F_MAX, F_MIN, '1, F_MAX, F_MIN, '1, 1));
		dir_tab.push_back(row(REQ_PREDICT, F_MAX, F_MIN, 16'd0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_PREDICT, 32'd100, -32'd100, 16'hffff, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_UNUSED, F_MAX, F_MAX, 16'hffff, F_MAX, F_MAX, '1, 1));
		dir_tab.push_back(row(REQ_PREDICT, 32'd262144, -32'd262144, 16'd1000, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_PREDICT, 0, 0, 16'd655, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_PREDICT, F_MAX, F_MIN, 16'hffff, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_PREDICT, F_MIN, F_MAX, 16'd1, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, F_MAX, F_MIN, 8'd0, 0));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, F_MAX, F_MIN, 8'd255, 0));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, F_MIN, F_MAX, 8'd49, 0));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, 32'd65536, -32'd65536, 8'd50, 0));
		dir_tab.push_back(row(REQ_PREDICT, F_MAX, F_MAX, 16'hffff, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, F_MIN, F_MIN, 8'd1, 0));
		dir_tab.push_back(row(REQ_RESTORE, 0, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_CORRECT, 0, 0, 0, 32'h00640000, 32'hff9c0000, 8'd128, 0));
		dir_tab.push_back(row(REQ_PREDICT, 32'h00100000, 32'hfff00000, 16'd6554, 0, 0, 0, 0));
		foreach (dir_tab[i]) send_request(dir_tab[i]);

		n_sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				in_ch.valid <= 1'b0;
				drain();
				case (ph)
					1: for (int r = 0; r <= REG_STILL_LIMIT; r++) reg_write(3'(r), 32'd0);
					2: begin
						for (int r = 0; r <= REG_STILL_LIMIT; r++) reg_write(3'(r), '1);
						reg_write(REG_MIN_QUAL, 32'd255);
					end
					3: begin
						reg_write(REG_PROC_NOISE, $urandom_range(0, 1 << 24));
						reg_write(REG_MEAS_NOISE, $urandom_range(0, 1 << 24));
						reg_write(REG_MIN_QUAL, $urandom_range(0, 255));
						reg_write(REG_ACC_DBAND, $urandom_range(0, 1 << 19));
						reg_write(REG_STILL_LIMIT, $urandom_range(0, 1 << 19));
					end
					default: for (int r = 0; r <= REG_STILL_LIMIT; r++) reg_write(3'(r), $urandom);
				endcase
			end
			for (int k = 0; k < 86; k++) begin
				if (n_sent > 390) quiet = 1;
				send_request(rand_request());
				n_sent++;
			end
		end
		in_ch.valid <= 1'b0;

		while (state_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("position_velocity_kalman_2d test passed");
		end else begin
			$display("position_velocity_kalman_2d test failed");
		end
		$finish;
	end

endmodule

[sim.f]
sv/pvk_pkg.sv
sv/pvk_if.sv
sv/pvk_alu.sv
sv/position_velocity_kalman_2d.sv
sv/pvk_chk.sv
tb/tb_position_velocity_kalman_2d.sv
